[rtl/mpma_pkg.sv]
// Shared types and constants of the multi-pattern match automaton.
package mpma_pkg;

  localparam int NODES   = 256;
  localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SYM_W   = 8;
  localparam int EDGE_AW = NODE_W + SYM_W;
  localparam int BUD_W   = $clog2(NODES + 1);

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_INFO  = 2'd1,
    OP_ROOT  = 2'd2,
    OP_PARSE = 2'd3
  } op_t;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] target;
  } edge_ent_t;

  typedef struct packed {
    logic               wr;
    logic [EDGE_AW-1:0] addr;
    edge_ent_t          wdata;
  } edge_req_t;

endpackage

[rtl/mpma_edge_store.sv]
// Goto edge memory with a clearing sweep after reset.
module mpma_edge_store (
  input  logic               clk,
  input  logic               rst_n,
  input  mpma_pkg::edge_req_t req,
  output mpma_pkg::edge_ent_t rd_data,
  output logic               clearing
);
  import mpma_pkg::*;

  edge_ent_t          mem [2**EDGE_AW];
  logic [EDGE_AW-1:0] clr_cnt_r;
  logic [EDGE_AW-1:0] clr_cnt_nxt;
  logic               clearing_r;
  logic               clearing_nxt;
  logic               wr_en;
  logic [EDGE_AW-1:0] wr_addr;
  edge_ent_t          wr_data;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (&clr_cnt_r) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  // sweep owns the write port until done
  always_comb begin
    wr_en   = clearing_r | req.wr;
    wr_addr = clearing_r ? clr_cnt_r : req.addr;
    wr_data = clearing_r ? edge_ent_t'('0) : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[req.addr];
  end

  assign clearing = clearing_r;

endmodule

[rtl/multi_pattern_match_automaton_top.sv]
// Top level of the Aho-Corasick byte matcher: request sequencer and node info memory.
// Edge, node info and root requests answer in the cycle after accept. A parse first reads
// the edge, then follows k failure links (k <= NODES), each one node info read then one
// edge read, plus a final root try when the link budget runs out; it ends with a length read.
// Throughput: one request in flight; busy is low again in the cycle the result shows.
// Reset: current node to the root; edge memory swept clear one entry per cycle
// with busy high. Results cannot be stalled.
module multi_pattern_match_automaton_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_node,
  input  logic [7:0]  in_symbol,
  input  logic [7:0]  in_next_node,
  input  logic        in_edge_valid,
  input  logic [7:0]  in_failure_node,
  input  logic [7:0]  in_report_length,
  output logic        out_valid,
  output logic [7:0]  out_match_length
);
  import mpma_pkg::*;

  // Walk sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for a request
    S_EDGE = 4'b0010,  // edge read data arrives
    S_FAIL = 4'b0100,  // failure link read data arrives
    S_LEN  = 4'b1000   // report length read data arrives
  } state_t;

  // Node info entry: failure link and report length
  typedef struct packed {
    logic [NODE_W-1:0] fail;
    logic [7:0]        len;
  } info_t;

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [BUD_W-1:0]  budget_r, budget_nxt;
  logic              last_r, last_nxt;     // final root try after budget ran out
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_len_r, out_len_nxt;

  edge_req_t         edge_req;
  edge_ent_t         edge_rd;
  logic              clearing;

  info_t             info_mem [NODES];
  info_t             info_rd;
  logic              info_we;
  logic [NODE_W-1:0] info_addr;
  info_t             info_wdata;

  logic              accept;
  logic              node_ok;
  logic              next_ok;
  logic              fail_ok;

  mpma_edge_store u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (edge_req),
    .rd_data  (edge_rd),
    .clearing (clearing)
  );

  assign busy   = clearing | (state_r != S_IDLE);
  assign accept = start & ~busy;

  // Writes that name a node outside the automaton are dropped whole
  assign node_ok = 32'(in_node) < NODES;
  assign next_ok = 32'(in_next_node) < NODES;
  assign fail_ok = 32'(in_failure_node) < NODES;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    sym_nxt       = sym_r;
    budget_nxt    = budget_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_len_nxt   = out_len_r;

    edge_req       = '0;
    edge_req.addr  = {cur_r, sym_r};
    info_we        = 1'b0;
    info_addr      = cur_r;
    info_wdata.fail = NODE_W'(in_failure_node);
    info_wdata.len  = in_report_length;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_op))
            OP_EDGE: begin
              edge_req.addr = {NODE_W'(in_node), in_symbol};
              edge_req.wdata.valid  = in_edge_valid;
              edge_req.wdata.target = in_edge_valid ? NODE_W'(in_next_node) : '0;
              edge_req.wr   = node_ok & (~in_edge_valid | next_ok);
              out_valid_nxt = 1'b1;
              out_len_nxt   = '0;
            end
            OP_INFO: begin
              info_we       = node_ok & fail_ok;
              info_addr     = NODE_W'(in_node);
              out_valid_nxt = 1'b1;
              out_len_nxt   = '0;
            end
            OP_ROOT: begin
              cur_nxt       = '0;
              out_valid_nxt = 1'b1;
              out_len_nxt   = '0;
            end
            OP_PARSE: begin
              sym_nxt       = in_symbol;
              edge_req.addr = {cur_r, in_symbol};
              budget_nxt    = BUD_W'(NODES);
              last_nxt      = 1'b0;
              state_nxt     = S_EDGE;
            end
            default: ;
          endcase
        end
      end

      S_EDGE: begin
        priority if (edge_rd.valid) begin
          // take the edge, then fetch the landing node's length
          cur_nxt   = edge_rd.target;
          info_addr = edge_rd.target;
          state_nxt = S_LEN;
        end else if (last_r || cur_r == '0) begin
          cur_nxt   = '0;
          info_addr = '0;
          state_nxt = S_LEN;
        end else if (budget_r == '0) begin
          // link budget spent: one more try from the root
          cur_nxt       = '0;
          last_nxt      = 1'b1;
          edge_req.addr = {{NODE_W{1'b0}}, sym_r};
          state_nxt     = S_EDGE;
        end else begin
          budget_nxt = budget_r - 1'b1;
          info_addr  = cur_r;
          state_nxt  = S_FAIL;
        end
      end

      S_FAIL: begin
        cur_nxt       = info_rd.fail;
        edge_req.addr = {info_rd.fail, sym_r};
        state_nxt     = S_EDGE;
      end

      S_LEN: begin
        out_valid_nxt = 1'b1;
        out_len_nxt   = info_rd.len;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      budget_r    <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      budget_r    <= budget_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r     <= sym_nxt;
    out_len_r <= out_len_nxt;
  end

  // Node info memory: single port, registered read
  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_addr] <= info_wdata;
    end
    info_rd <= info_mem[info_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_match_length = out_len_r;

`ifndef SYNTH
  // Non-parse requests answer on the next cycle with length zero
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op != OP_PARSE |=> out_valid && out_match_length == 8'd0)
    else $error("non-parse request did not produce a zero result");

  // A parse needs at least the edge and length reads before it answers
  a_parse_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == OP_PARSE |=> !out_valid ##1 !out_valid)
    else $error("parse result came too early");

  // No request accepted while the edge memory sweep runs
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> busy && !out_valid)
    else $error("activity during edge memory clear");

  // Link budget never exceeds the node count
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    32'(budget_r) <= NODES)
    else $error("failure link budget out of range");
`endif

endmodule
